// File: hdl/assert_macros.svh
// Assertion macros shared by the 1-Wire master RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define ASSERT_AT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/owbm_pkg.sv
// Shared types, codes and constants of the 1-Wire bus master.
package owbm_pkg;

    localparam int CFG_W      = 10;
    localparam int NUM_REGS   = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int PHASE_W    = 4;
    localparam int BYTE_W     = 8;
    localparam int BIT_IDX_W  = 3;

    localparam int DEFAULT_READ_SAMPLE_DELAY = 5;
    localparam int DEFAULT_TICK_COUNT_BITS   = 10;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Request codes on req_type.
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_RESET = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] R_RESET_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] R_PRES_WAIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] R_RESET_TAIL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] R_W0_LOW     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] R_W1_LOW     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] R_WSLOT      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] R_RD_LOW     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] R_RD_TAIL    = 3'd7;

    // Register values after reset.
    localparam logic [CFG_W-1:0] RST_RESET_LOW  = 10'd480;
    localparam logic [CFG_W-1:0] RST_PRES_WAIT  = 10'd70;
    localparam logic [CFG_W-1:0] RST_RESET_TAIL = 10'd410;
    localparam logic [CFG_W-1:0] RST_W0_LOW     = 10'd65;
    localparam logic [CFG_W-1:0] RST_W1_LOW     = 10'd10;
    localparam logic [CFG_W-1:0] RST_WSLOT      = 10'd75;
    localparam logic [CFG_W-1:0] RST_RD_LOW     = 10'd5;
    localparam logic [CFG_W-1:0] RST_RD_TAIL    = 10'd55;

    // Sequencer phases.
    localparam logic [PHASE_W-1:0] PH_IDLE     = 4'd0;
    localparam logic [PHASE_W-1:0] PH_RST_LOW  = 4'd1;
    localparam logic [PHASE_W-1:0] PH_RST_WAIT = 4'd2;
    localparam logic [PHASE_W-1:0] PH_RST_TAIL = 4'd3;
    localparam logic [PHASE_W-1:0] PH_WR_LOW   = 4'd4;
    localparam logic [PHASE_W-1:0] PH_WR_REC   = 4'd5;
    localparam logic [PHASE_W-1:0] PH_RD_LOW   = 4'd6;
    localparam logic [PHASE_W-1:0] PH_RD_WAIT  = 4'd7;
    localparam logic [PHASE_W-1:0] PH_RD_TAIL  = 4'd8;

    // One classified tick request as it travels from front to back.
    typedef struct packed {
        logic              start_reset;
        logic              start_write;
        logic              start_read;
        logic              cmd;
        logic [BYTE_W-1:0] write_byte;
        logic              line_in;
    } owbm_item_t;

    // A timing value of zero counts as one tick.
    function automatic logic [CFG_W-1:0] at_least_one(input logic [CFG_W-1:0] v);
        at_least_one = (v == '0) ? CFG_W'(1) : v;
    endfunction

endpackage

// File: hdl/owbm_front.sv
// Front end: accepts tick requests, decodes the command and queues them.
`include "assert_macros.svh"

module owbm_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     req_type,
    input  logic [owbm_pkg::BYTE_W-1:0]    write_byte,
    input  logic                           line_in,
    output logic                           item_valid,
    input  logic                           item_ready,
    output owbm_pkg::owbm_item_t           item
);
    import owbm_pkg::*;

    owbm_item_t        q_mem [QUEUE_DEPTH];
    owbm_item_t        decoded;
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push;
    logic              pop;

    always_comb
    begin
        decoded.start_reset = (req_type == REQ_RESET);
        decoded.start_write = (req_type == REQ_WRITE);
        decoded.start_read  = (req_type == REQ_READ);
        decoded.cmd         = (req_type != REQ_TICK);
        decoded.write_byte  = write_byte;
        decoded.line_in     = line_in;
    end

    assign in_ready   = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign item_valid = (count_reg != '0);
    assign item       = q_mem[rd_ptr_reg];
    assign push       = in_valid && in_ready;
    assign pop        = item_valid && item_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= decoded;
        end
    end

    `ASSERT_AT_CLK(a_count_bound, clk, rst_n, count_reg <= QCNT_W'(QUEUE_DEPTH), "queue count overflow")
    `ASSERT_AT_CLK(a_empty_ptrs, clk, rst_n, (count_reg != '0) || (rd_ptr_reg == wr_ptr_reg), "empty queue with pointers apart")
    `ASSERT_NEXT(a_fill, clk, rst_n, push && !pop && (count_reg == '0), count_reg == QCNT_W'(1), "push into empty queue lost")

endmodule

// File: hdl/owbm_back.sv
// Back end: slot timing sequencer, configuration registers and result register.
`include "assert_macros.svh"

module owbm_back #(
    parameter int READ_SAMPLE_DELAY = owbm_pkg::DEFAULT_READ_SAMPLE_DELAY,
    parameter int TICK_COUNT_BITS   = owbm_pkg::DEFAULT_TICK_COUNT_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [owbm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [owbm_pkg::CFG_W-1:0]       cfg_data,
    input  logic                             item_valid,
    output logic                             item_ready,
    input  owbm_pkg::owbm_item_t             item,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             drive_low,
    output logic                             busy_res,
    output logic                             done_res,
    output logic                             presence_ok,
    output logic [owbm_pkg::BYTE_W-1:0]      read_result,
    output logic                             rejected
);
    import owbm_pkg::*;

    localparam int TC_W   = TICK_COUNT_BITS;
    localparam int WIDE_W = (TICK_COUNT_BITS > CFG_W) ? TICK_COUNT_BITS : CFG_W;

    logic [CFG_W-1:0]     cfg_reg [NUM_REGS];

    logic [PHASE_W-1:0]   phase_reg, phase_next;
    logic [TC_W-1:0]      tick_count_reg, tick_count_next;
    logic [BIT_IDX_W-1:0] bit_index_reg, bit_index_next;
    logic [BYTE_W-1:0]    shift_reg, shift_next;
    logic                 pres_low_reg, pres_low_next;
    logic                 pres_result_reg, pres_result_next;
    logic [BYTE_W-1:0]    read_byte_reg, read_byte_next;

    logic                 out_valid_reg;
    logic                 drive_reg, busy_reg, done_reg, rej_reg;
    logic                 drive_c, busy_c, done_c, rej_c;

    logic [CFG_W-1:0]     write_low;
    logic [CFG_W-1:0]     raw_len;
    logic [WIDE_W-1:0]    raw_wide;
    logic [WIDE_W-1:0]    max_wide;
    logic [TC_W-1:0]      phase_len;
    logic                 pop;

    assign item_ready = !out_valid_reg || out_ready;
    assign pop        = item_valid && item_ready;

    always_comb
    begin
        phase_next       = (phase_reg > PH_RD_TAIL) ? PH_IDLE : phase_reg;
        tick_count_next  = tick_count_reg;
        bit_index_next   = bit_index_reg;
        shift_next       = shift_reg;
        pres_low_next    = pres_low_reg;
        pres_result_next = pres_result_reg;
        read_byte_next   = read_byte_reg;
        drive_c          = 1'b0;
        busy_c           = 1'b0;
        done_c           = 1'b0;
        rej_c            = 1'b0;

        // Idle: a command starts an operation on this very tick.
        if (phase_next == PH_IDLE)
        begin
            tick_count_next = '0;
            bit_index_next  = '0;
            if (item.start_reset)
            begin
                pres_low_next = 1'b0;
                phase_next    = PH_RST_LOW;
            end
            else if (item.start_write)
            begin
                shift_next = item.write_byte;
                phase_next = PH_WR_LOW;
            end
            else if (item.start_read)
            begin
                shift_next = '0;
                phase_next = PH_RD_LOW;
            end
        end
        else if (item.cmd)
        begin
            rej_c = 1'b1;
        end

        write_low = at_least_one(shift_next[bit_index_next] ? cfg_reg[R_W1_LOW]
                                                             : cfg_reg[R_W0_LOW]);
        case (phase_next)
            PH_RST_LOW:  raw_len = at_least_one(cfg_reg[R_RESET_LOW]);
            PH_RST_WAIT: raw_len = at_least_one(cfg_reg[R_PRES_WAIT]);
            PH_RST_TAIL: raw_len = at_least_one(cfg_reg[R_RESET_TAIL]);
            PH_WR_LOW:   raw_len = write_low;
            PH_WR_REC:   raw_len = (cfg_reg[R_WSLOT] > write_low) ?
                                   cfg_reg[R_WSLOT] - write_low : CFG_W'(1);
            PH_RD_LOW:   raw_len = at_least_one(cfg_reg[R_RD_LOW]);
            PH_RD_WAIT:  raw_len = at_least_one(CFG_W'(READ_SAMPLE_DELAY));
            default:     raw_len = at_least_one(cfg_reg[R_RD_TAIL]);
        endcase

        // Saturate to what the tick counter can hold.
        raw_wide  = WIDE_W'(raw_len);
        max_wide  = WIDE_W'((1 << TICK_COUNT_BITS) - 1);
        phase_len = TC_W'((raw_wide > max_wide) ? max_wide : raw_wide);

        if (phase_next != PH_IDLE)
        begin
            busy_c  = 1'b1;
            drive_c = (phase_next == PH_RST_LOW) || (phase_next == PH_WR_LOW) ||
                      (phase_next == PH_RD_LOW);
            if (({1'b0, tick_count_next} + 1'b1) >= {1'b0, phase_len})
            begin
                tick_count_next = '0;
                case (phase_next)
                    PH_RST_LOW:
                    begin
                        phase_next = PH_RST_WAIT;
                    end
                    PH_RST_WAIT:
                    begin
                        pres_low_next = !item.line_in;
                        phase_next    = PH_RST_TAIL;
                    end
                    PH_RST_TAIL:
                    begin
                        pres_result_next = pres_low_next && item.line_in;
                        done_c           = 1'b1;
                        phase_next       = PH_IDLE;
                    end
                    PH_WR_LOW:
                    begin
                        phase_next = PH_WR_REC;
                    end
                    PH_WR_REC:
                    begin
                        if (bit_index_next == '1)
                        begin
                            done_c         = 1'b1;
                            bit_index_next = '0;
                            phase_next     = PH_IDLE;
                        end
                        else
                        begin
                            bit_index_next = bit_index_next + 1'b1;
                            phase_next     = PH_WR_LOW;
                        end
                    end
                    PH_RD_LOW:
                    begin
                        phase_next = PH_RD_WAIT;
                    end
                    PH_RD_WAIT:
                    begin
                        if (item.line_in)
                        begin
                            shift_next[bit_index_next] = 1'b1;
                        end
                        phase_next = PH_RD_TAIL;
                    end
                    default:
                    begin
                        if (bit_index_next == '1)
                        begin
                            read_byte_next = shift_next;
                            done_c         = 1'b1;
                            bit_index_next = '0;
                            phase_next     = PH_IDLE;
                        end
                        else
                        begin
                            bit_index_next = bit_index_next + 1'b1;
                            phase_next     = PH_RD_LOW;
                        end
                    end
                endcase
            end
            else
            begin
                tick_count_next = tick_count_next + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[R_RESET_LOW]  <= RST_RESET_LOW;
            cfg_reg[R_PRES_WAIT]  <= RST_PRES_WAIT;
            cfg_reg[R_RESET_TAIL] <= RST_RESET_TAIL;
            cfg_reg[R_W0_LOW]     <= RST_W0_LOW;
            cfg_reg[R_W1_LOW]     <= RST_W1_LOW;
            cfg_reg[R_WSLOT]      <= RST_WSLOT;
            cfg_reg[R_RD_LOW]     <= RST_RD_LOW;
            cfg_reg[R_RD_TAIL]    <= RST_RD_TAIL;
            phase_reg             <= PH_IDLE;
            tick_count_reg        <= '0;
            bit_index_reg         <= '0;
            shift_reg             <= '0;
            pres_low_reg          <= 1'b0;
            pres_result_reg       <= 1'b0;
            read_byte_reg         <= '0;
            out_valid_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cfg_reg[cfg_index] <= cfg_data;
            end
            if (pop)
            begin
                phase_reg       <= phase_next;
                tick_count_reg  <= tick_count_next;
                bit_index_reg   <= bit_index_next;
                shift_reg       <= shift_next;
                pres_low_reg    <= pres_low_next;
                pres_result_reg <= pres_result_next;
                read_byte_reg   <= read_byte_next;
                out_valid_reg   <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            drive_reg <= drive_c;
            busy_reg  <= busy_c;
            done_reg  <= done_c;
            rej_reg   <= rej_c;
        end
    end

    assign out_valid   = out_valid_reg;
    assign drive_low   = drive_reg;
    assign busy_res    = busy_reg;
    assign done_res    = done_reg;
    assign rejected    = rej_reg;
    assign presence_ok = pres_result_reg;
    assign read_result = read_byte_reg;

    `ASSERT_AT_CLK(a_done_busy, clk, rst_n, !(out_valid_reg && done_reg) || busy_reg, "done without busy")
    `ASSERT_AT_CLK(a_drive_busy, clk, rst_n, !(out_valid_reg && drive_reg) || busy_reg, "bus driven while idle")
    `ASSERT_AT_CLK(a_idle_clear, clk, rst_n, (phase_reg != PH_IDLE) || ((tick_count_reg == '0) && (bit_index_reg == '0)), "idle with counters set")

endmodule

// File: hdl/one_wire_bus_master_core.sv
// Top level of the 1-Wire bus master: front end, request queue and slot sequencer.

// Every request is one bus tick (one microsecond in normal use) and produces exactly one
// result, so the block sustains one request per clock cycle while results are read: the
// front end accepts a request whenever its two-entry queue has room, and the sequencer
// retires one queued request per cycle into the output register whenever that register
// is empty or being read. Requests are queued and results registered. The sequencer runs
// reset with presence detect (req_type 1), byte write (2) and byte read (3), least
// significant bit first, with the slot timings held in eight configuration registers
// written through cfg_we, cfg_index and cfg_data; write them only while the block is idle.
// A command that arrives while an operation is running is dropped and flagged on
// rejected. drive_low is meant to control an open-drain pull-down on the bus.
module one_wire_bus_master_core #(
    parameter int READ_SAMPLE_DELAY = owbm_pkg::DEFAULT_READ_SAMPLE_DELAY,
    parameter int TICK_COUNT_BITS   = owbm_pkg::DEFAULT_TICK_COUNT_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [owbm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [owbm_pkg::CFG_W-1:0]       cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       req_type,
    input  logic [owbm_pkg::BYTE_W-1:0]      write_byte,
    input  logic                             line_in,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             drive_low,
    output logic                             busy_res,
    output logic                             done_res,
    output logic                             presence_ok,
    output logic [owbm_pkg::BYTE_W-1:0]      read_result,
    output logic                             rejected
);
    import owbm_pkg::*;

    // Decoded requests waiting for the sequencer.
    owbm_item_t item;
    logic       item_valid;
    logic       item_ready;

    // The front end decodes each request and holds it until the sequencer takes it,
    // so a stalled result blocks the request side only once the queue is full.
    owbm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .write_byte (write_byte),
        .line_in    (line_in),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    // The sequencer advances the bus timing by one tick for every request it retires.
    owbm_back #(
        .READ_SAMPLE_DELAY (READ_SAMPLE_DELAY),
        .TICK_COUNT_BITS   (TICK_COUNT_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .drive_low   (drive_low),
        .busy_res    (busy_res),
        .done_res    (done_res),
        .presence_ok (presence_ok),
        .read_result (read_result),
        .rejected    (rejected)
    );

endmodule
